### hdl/hcp_pkg.sv
// Shared constants and types for the Huffman code packer.
`timescale 1ns / 1ps
package hcp_pkg;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = 8;
    localparam int SYM_AW       = $clog2(SYMBOL_COUNT);
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int ENTRY_W      = LEN_W + CODE_W;
    localparam int WORD_W       = 64;
    localparam int FILL_W       = 6;
    localparam int CNT_W        = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FINISH = 2'd2
    } t_opcode;
endpackage

### hdl/huffman_code_packer_core.sv
// Top level of the Huffman code packer: code table, bit accumulator and output stage.
`timescale 1ns / 1ps
// The packer accepts one item per cycle while its input is not stalled. Each encode
// or finish item passes two steps in order: the first reads the code table, whose read data is
// registered, and the second shifts the code into the 64-bit accumulator and
// loads the output register. Loads write the table at their input transfer, so an
// encode may follow a load of the same symbol in the next cycle. Encoding a symbol
// that was never loaded gives undefined bits. The input stalls only when a result
// is waiting in the output register and the output side is stalled.
module huffman_code_packer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [hcp_pkg::SYM_W-1:0]   i_symbol,
    input  logic [hcp_pkg::CODE_W-1:0]  i_code_bits,
    input  logic [hcp_pkg::LEN_W-1:0]   i_code_length,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hcp_pkg::WORD_W-1:0]  o_packed_word,
    output logic [hcp_pkg::CNT_W-1:0]   o_byte_count,
    output logic [hcp_pkg::CNT_W-1:0]   o_pad_bits,
    output logic                        o_last
);
    import hcp_pkg::*;

    localparam int WIN_W = WORD_W + CODE_W;

    logic                  in_xfer;
    logic                  sym_ok;
    logic [LEN_W-1:0]      len_sat;
    logic [CODE_W-1:0]     code_mask;
    logic [ENTRY_W-1:0]    wr_entry;
    logic [ENTRY_W-1:0]    rd_entry;
    logic                  stage_fire;

    logic                  r_v1;
    logic                  r_fin1;
    logic [WORD_W-1:0]     r_acc;
    logic [FILL_W-1:0]     r_fill;
    logic                  r_ov;
    logic [WORD_W-1:0]     r_word;
    logic [CNT_W-1:0]      r_bytes;
    logic [CNT_W-1:0]      r_pad;
    logic                  r_last;

    logic [LEN_W-1:0]      len;
    logic [CODE_W-1:0]     code;
    logic [CODE_W-1:0]     code_left;
    logic [WIN_W-1:0]      window;
    logic [FILL_W:0]       sum;
    logic [FILL_W:0]       junk;
    logic [FILL_W:0]       junk_m1;
    logic [2:0]            junk_bytes;
    logic [FILL_W:0]       pad_full;

    logic [WORD_W-1:0]     n_acc;
    logic [FILL_W-1:0]     n_fill;
    logic                  n_res;
    logic [WORD_W-1:0]     n_word;
    logic [CNT_W-1:0]      n_bytes;
    logic [CNT_W-1:0]      n_pad;
    logic                  n_last;

    assign stage_fire = r_v1 && (!r_ov || !i_out_stall);
    assign o_in_stall = r_v1 && r_ov && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign sym_ok     = ({1'b0, i_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));

    always_comb begin
        len_sat = (i_code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                          : i_code_length;
        if (len_sat >= LEN_W'(CODE_W)) begin
            code_mask = '1;
        end else begin
            code_mask = (CODE_W'(1) << len_sat) - CODE_W'(1);
        end
        wr_entry = {len_sat, i_code_bits & code_mask};
    end

    hcp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SYMBOL_COUNT)
    ) u_code_table (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && (i_opcode == OP_LOAD) && sym_ok),
        .i_wr_addr (i_symbol[SYM_AW-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (in_xfer),
        .i_rd_addr (i_symbol[SYM_AW-1:0]),
        .o_rd_data (rd_entry)
    );

    always_comb begin
        len        = rd_entry[ENTRY_W-1:CODE_W];
        code       = rd_entry[CODE_W-1:0];
        code_left  = code << (LEN_W + 1)'((LEN_W + 1)'(CODE_W) - {1'b0, len});
        window     = {r_acc, CODE_W'(0)} | ({code_left, WORD_W'(0)} >> r_fill);
        sum        = {1'b0, r_fill} + (FILL_W + 1)'(len);
        junk       = (FILL_W + 1)'(WORD_W) - {1'b0, r_fill};
        junk_m1    = junk - (FILL_W + 1)'(1);
        junk_bytes = junk_m1[5:3];
        pad_full   = junk - {1'b0, junk_bytes, 3'b000};

        n_acc   = r_acc;
        n_fill  = r_fill;
        n_res   = 1'b0;
        n_word  = r_acc;
        n_bytes = CNT_W'(8);
        n_pad   = '0;
        n_last  = 1'b0;
        if (r_fin1) begin
            n_res   = 1'b1;
            n_word  = r_acc;
            n_bytes = CNT_W'(8) - CNT_W'(junk_bytes);
            n_pad   = pad_full[CNT_W-1:0];
            n_last  = 1'b1;
            n_acc   = '0;
            n_fill  = '0;
        end else if (sum[FILL_W]) begin
            n_res  = 1'b1;
            n_word = window[WIN_W-1:CODE_W];
            n_acc  = {window[CODE_W-1:0], CODE_W'(0)};
            n_fill = sum[FILL_W-1:0];
        end else begin
            n_acc  = window[WIN_W-1:CODE_W];
            n_fill = sum[FILL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_fin1 <= 1'b0;
            r_acc  <= '0;
            r_fill <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_v1   <= i_in_valid && (((i_opcode == OP_ENCODE) && sym_ok) ||
                                         (i_opcode == OP_FINISH));
                r_fin1 <= (i_opcode == OP_FINISH);
            end
            if (stage_fire) begin
                r_acc  <= n_acc;
                r_fill <= n_fill;
            end
            if (stage_fire && n_res) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_fire && n_res) begin
            r_word  <= n_word;
            r_bytes <= n_bytes;
            r_pad   <= n_pad;
            r_last  <= n_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_packed_word = r_word;
    assign o_byte_count  = r_bytes;
    assign o_pad_bits    = r_pad;
    assign o_last        = r_last;
endmodule

### hdl/hcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AddrW-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### sim/huffman_code_packer_checker.sv
// Checker for the Huffman code packer: predicts every packed word and compares it with the DUT.
`timescale 1ns / 1ps
module huffman_code_packer_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [hcp_pkg::SYM_W-1:0]   i_symbol,
    input  logic [hcp_pkg::CODE_W-1:0]  i_code_bits,
    input  logic [hcp_pkg::LEN_W-1:0]   i_code_length,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [hcp_pkg::WORD_W-1:0]  i_packed_word,
    input  logic [hcp_pkg::CNT_W-1:0]   i_byte_count,
    input  logic [hcp_pkg::CNT_W-1:0]   i_pad_bits,
    input  logic                        i_last,
    output int                          o_fail_count,
    output int                          o_pending
);
    import hcp_pkg::*;

    localparam int BYTE_W     = 8;
    localparam int WORD_BYTES = WORD_W / BYTE_W;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  byte_count;
        logic [CNT_W-1:0]  pad_bits;
        logic              last;
    } t_packer_word;

    logic [ENTRY_W-1:0] code_table [SYMBOL_COUNT];
    logic [WORD_W-1:0]  bit_acc;
    int                 bits_held;
    t_packer_word       expected_words [$];
    int                 fails;

    // Applies one accepted item to the local copy of the packer state.
    task automatic pack_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code_in,
                             input logic [LEN_W-1:0] len_in,
                             output bit emits, output t_packer_word res);
        logic [WORD_W-1:0] code;
        int                len;
        int                space;
        int                rest;
        int                junk;
        int                junk_bytes;
        emits = 1'b0;
        res   = '0;
        case (t_opcode'(op))
            OP_LOAD: begin
                if (int'(sym) < SYMBOL_COUNT) begin
                    len = int'(len_in);
                    if (len > MAX_CODE_LEN)
                        len = MAX_CODE_LEN;
                    code = {{(WORD_W-CODE_W){1'b0}}, code_in};
                    if (len < CODE_W)
                        code &= (64'd1 << len) - 64'd1;
                    code_table[sym] = {LEN_W'(len), code[CODE_W-1:0]};
                end
            end
            OP_ENCODE: begin
                if (int'(sym) < SYMBOL_COUNT) begin
                    len   = int'(code_table[sym][ENTRY_W-1:CODE_W]);
                    code  = {{(WORD_W-CODE_W){1'b0}}, code_table[sym][CODE_W-1:0]};
                    space = WORD_W - bits_held;
                    if (len == 0) begin
                    end else if (len < space) begin
                        bit_acc   |= code << (space - len);
                        bits_held += len;
                    end else begin
                        rest  = len - space;
                        emits = 1'b1;
                        res.word       = bit_acc | (code >> rest);
                        res.byte_count = CNT_W'(WORD_BYTES);
                        bit_acc   = (rest == 0) ? '0 : code << (WORD_W - rest);
                        bits_held = rest;
                    end
                end
            end
            OP_FINISH: begin
                junk       = WORD_W - bits_held;
                junk_bytes = (junk - 1) / BYTE_W;
                emits          = 1'b1;
                res.word       = bit_acc;
                res.byte_count = CNT_W'(WORD_BYTES - junk_bytes);
                res.pad_bits   = CNT_W'(junk - BYTE_W * junk_bytes);
                res.last       = 1'b1;
                bit_acc   = '0;
                bits_held = 0;
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        fails = 0;
        bit_acc = '0;
        bits_held = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_packer_word got;
        t_packer_word want;
        bit           emits;
        if (!i_rst_n) begin
            bit_acc = '0;
            bits_held = 0;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_packed_word, i_byte_count, i_pad_bits, i_last};
                if (expected_words.size() == 0) begin
                    $error("unexpected result transfer: word %h", i_packed_word);
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.word !== want.word) begin
                        $error("packed_word: expected %h, got %h", want.word, got.word);
                        fails++;
                    end
                    if (got.byte_count !== want.byte_count) begin
                        $error("byte_count: expected %0d, got %0d",
                               want.byte_count, got.byte_count);
                        fails++;
                    end
                    if (got.pad_bits !== want.pad_bits) begin
                        $error("pad_bits: expected %0d, got %0d", want.pad_bits, got.pad_bits);
                        fails++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pack_item(i_opcode, i_symbol, i_code_bits, i_code_length, emits, want);
                if (emits)
                    expected_words.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_words.size();
    end
endmodule

### sim/huffman_code_packer_core_tb.sv
// Testbench top for the Huffman code packer: clock, reset, item stimulus and final verdict.
`timescale 1ns / 1ps
module huffman_code_packer_core_tb;
    import hcp_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RAND_ITEMS  = 1100;
    localparam int         PHASE_COUNT = 3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_opcode;
    logic [SYM_W-1:0]    i_symbol;
    logic [CODE_W-1:0]   i_code_bits;
    logic [LEN_W-1:0]    i_code_length;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [WORD_W-1:0]   o_packed_word;
    logic [CNT_W-1:0]    o_byte_count;
    logic [CNT_W-1:0]    o_pad_bits;
    logic                o_last;
    int                  fail_count;
    int                  pending;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    bit                  loaded [SYMBOL_COUNT];

    huffman_code_packer_core dut (.*);

    huffman_code_packer_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_packed_word (o_packed_word),
        .i_byte_count  (o_byte_count),
        .i_pad_bits    (o_pad_bits),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < recv_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_opcode      = op;
        i_symbol      = sym;
        i_code_bits   = code;
        i_code_length = len;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                              input logic [LEN_W-1:0] len);
        loaded[sym] = 1'b1;
        send_item(OP_LOAD, sym, code, len);
    endtask

    task automatic encode_symbol(input logic [SYM_W-1:0] sym);
        send_item(OP_ENCODE, sym, $urandom(), LEN_W'($urandom_range(63)));
    endtask

    task automatic random_item();
        int                pick;
        int                len_pick;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        pick = $urandom_range(99);
        if (pick < 15) begin
            len_pick = $urandom_range(99);
            if (len_pick < 5)
                len = '0;
            else if (len_pick < 12)
                len = LEN_W'($urandom_range(63, MAX_CODE_LEN + 1));
            else
                len = LEN_W'($urandom_range(MAX_CODE_LEN, 1));
            load_entry(SYM_W'($urandom_range(SYMBOL_COUNT - 1)), $urandom(), len);
        end else if (pick < 90) begin
            do
                sym = SYM_W'($urandom_range(SYMBOL_COUNT - 1));
            while (!loaded[sym]);
            encode_symbol(sym);
        end else if (pick < 97) begin
            send_item(OP_FINISH, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
        end else begin
            send_item(OP_UNUSED, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
        end
    endtask

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_LOAD;
        i_symbol      = '0;
        i_code_bits   = '0;
        i_code_length = '0;
        i_out_stall   = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 50;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Table extremes: zero length, full length, saturated lengths, dropped upper bits.
        load_entry(8'd0, 32'hFFFF_FFFF, 6'd0);
        load_entry(8'd255, 32'hFFFF_FFFF, 6'd32);
        load_entry(8'd1, 32'hA5A5_A5A5, 6'd63);
        load_entry(8'd2, 32'h0000_0001, 6'd1);
        load_entry(8'd3, 32'h0000_0000, 6'd33);
        load_entry(8'd4, 32'hFFFF_FFAB, 6'd7);
        send_item(OP_FINISH, 8'd0, 32'h0, 6'd0);
        encode_symbol(8'd0);
        encode_symbol(8'd255);
        encode_symbol(8'd255);
        encode_symbol(8'd2);
        send_item(OP_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        encode_symbol(8'd2);
        encode_symbol(8'd255);
        encode_symbol(8'd255);
        encode_symbol(8'd1);
        send_item(OP_UNUSED, 8'd2, 32'hFFFF_FFFF, 6'h3F);
        encode_symbol(8'd4);
        encode_symbol(8'd3);
        send_item(OP_FINISH, 8'd0, 32'h0, 6'd0);
        load_entry(8'd5, 32'h0000_0155, 6'd9);
        encode_symbol(8'd5);
        send_item(OP_FINISH, 8'd0, 32'h0, 6'd0);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (RAND_ITEMS / PHASE_COUNT) random_item();
        end
        send_item(OP_FINISH, 8'd0, 32'h0, 6'd0);
        i_in_valid = 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
